FILE: hw/rtl/quadrature_encoder_with_switch_top_macros.svh
// Assertion macros shared by the encoder checker.
`ifndef QUADRATURE_ENCODER_WITH_SWITCH_TOP_MACROS_SVH
`define QUADRATURE_ENCODER_WITH_SWITCH_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define QESW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define QESW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: hw/rtl/qesw_pkg.sv
// Shared types and constants for the quadrature encoder with switch.
package qesw_pkg;

	localparam int COUNT_BITS   = 31;
	localparam int HISTORY_BITS = 4;
	localparam int LUT_BITS     = 2 * (1 << HISTORY_BITS);
	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_COUNT_LIMIT     = 2'd0,
		CFG_STEP_TABLE      = 2'd1,
		CFG_SWITCH_INTERVAL = 2'd2
	} cfg_index_t;

	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_LOAD = 1'b1
	} command_t;

	typedef struct packed {
		logic               command;
		logic               pin_a;
		logic               pin_b;
		logic               pin_switch;
		logic signed [31:0] load_value;
	} sample_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic                  count_changed;
		logic                  pressed;
		logic                  released;
		logic                  switch_level;
	} result_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] count_limit;
		logic [LUT_BITS-1:0]   step_table;
		logic [7:0]            switch_interval;
	} qesw_cfg_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0]   position;
		logic [HISTORY_BITS-1:0] phase_history;
		logic [7:0]              switch_countdown;
		logic                    switch_now;
		logic                    switch_before;
	} qesw_state_t;

	localparam qesw_state_t STATE_RESET = '{
		position:         '0,
		phase_history:    '0,
		switch_countdown: '0,
		switch_now:       1'b1,
		switch_before:    1'b1
	};

endpackage

FILE: hw/rtl/qesw_step.sv
// Per-item update: position load, or history, delta lookup, saturating count and switch edge detect.
module qesw_step import qesw_pkg::*; (
	input  qesw_cfg_t   cfg,
	input  qesw_state_t state,
	input  sample_t     item,
	output qesw_state_t state_next,
	output result_t     res
);

	logic [HISTORY_BITS-1:0] hist_next;
	logic [1:0]              delta;
	logic signed [COUNT_BITS+1:0] sum;
	logic [COUNT_BITS-1:0]   step_pos;
	logic [COUNT_BITS-1:0]   load_pos;

	always_comb begin
		hist_next = {state.phase_history[HISTORY_BITS-3:0], ~item.pin_a, ~item.pin_b};
		delta     = cfg.step_table[{hist_next, 1'b0} +: 2];
		sum       = signed'({2'b00, state.position})
		          + signed'({{COUNT_BITS{delta[1]}}, delta});
		// saturate into 0..count_limit
		if (sum[COUNT_BITS+1]) begin
			step_pos = '0;
		end else if (sum[COUNT_BITS:0] > {1'b0, cfg.count_limit}) begin
			step_pos = cfg.count_limit;
		end else begin
			step_pos = sum[COUNT_BITS-1:0];
		end
		if (item.load_value[31]) begin
			load_pos = '0;
		end else if (item.load_value[30:0] > 31'(cfg.count_limit)) begin
			load_pos = cfg.count_limit;
		end else begin
			load_pos = COUNT_BITS'(item.load_value[30:0]);
		end
	end

	always_comb begin
		state_next = state;
		res        = '0;
		case (command_t'(item.command))
			CMD_LOAD: begin
				state_next.position = load_pos;
			end
			CMD_TICK: begin
				if (state.switch_countdown != 8'd0) begin
					state_next.switch_countdown = state.switch_countdown - 8'd1;
				end else begin
					state_next.switch_before    = state.switch_now;
					state_next.switch_now       = item.pin_switch;
					res.released                = !state.switch_now && item.pin_switch;
					res.pressed                 = state.switch_now && !item.pin_switch;
					state_next.switch_countdown = (cfg.switch_interval == 8'd0) ? 8'd0
						: cfg.switch_interval - 8'd1;
				end
				state_next.phase_history = hist_next;
				if (delta != 2'b00) begin
					state_next.position = step_pos;
				end
				res.count_changed = (state_next.position != state.position);
			end
			default: begin
				state_next = state;
			end
		endcase
		res.count        = state_next.position;
		res.switch_level = state_next.switch_now;
	end

endmodule

FILE: hw/rtl/quadrature_encoder_with_switch_top.sv
// Quadrature encoder decoder with push switch: one result per request, one request per cycle
// while the result port is not stalled; a request goes into the input register and its result
// into the result register, which drives the result port. The single state update between
// them is what sets the rate, and the output register lets a new request in while a finished
// result still waits downstream; a second request waits until that result is taken.
module quadrature_encoder_with_switch_top import qesw_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sample_valid,
	output logic                    sample_stall,
	input  sample_t                 sample,
	output logic                    result_valid,
	input  logic                    result_stall,
	output result_t                 result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [31:0]             cfg_data
);

	qesw_cfg_t   cfg_q;
	qesw_state_t state_q;
	qesw_state_t state_next;
	result_t     res_next;
	result_t     result_q;
	sample_t     item_s1;
	logic        valid_s1;
	logic        result_valid_q;
	logic        advance;

	assign cfg_ready    = 1'b1;
	assign advance      = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_limit     <= '0;
			cfg_q.step_table      <= '0;
			cfg_q.switch_interval <= 8'd8;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_COUNT_LIMIT:     cfg_q.count_limit     <= cfg_data[COUNT_BITS-1:0];
				CFG_STEP_TABLE:      cfg_q.step_table      <= cfg_data[LUT_BITS-1:0];
				CFG_SWITCH_INTERVAL: cfg_q.switch_interval <= cfg_data[7:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	qesw_step u_step (
		.cfg        (cfg_q),
		.state      (state_q),
		.item       (item_s1),
		.state_next (state_next),
		.res        (res_next)
	);

	// control: input stage, result stage and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			state_q        <= STATE_RESET;
		end else begin
			if (!valid_s1 || advance) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q <= state_next;
				end
			end
		end
	end

	// payload: hold while stalled
	always_ff @(posedge clk) begin
		if (!valid_s1 || advance) begin
			item_s1 <= sample;
		end
		if (advance && valid_s1) begin
			result_q <= res_next;
		end
	end

endmodule

FILE: hw/rtl/qesw_checker.sv
// Port-level checker for the quadrature encoder with switch, bound to the top level.
`include "quadrature_encoder_with_switch_top_macros.svh"

module qesw_checker import qesw_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    sample_valid,
	input logic                    sample_stall,
	input sample_t                 sample,
	input logic                    result_valid,
	input logic                    result_stall,
	input result_t                 result,
	input logic                    cfg_valid,
	input logic                    cfg_ready,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [31:0]             cfg_data
);

	// a stalled result holds
	`QESW_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result))
	// an empty output never backs up the input
	`QESW_ASSERT_IMP(a_no_stall_when_empty, clk, arst_n, !result_valid, !sample_stall)
	// press and release are exclusive and agree with the sampled level
	`QESW_ASSERT_IMP(a_press_level, clk, arst_n, result_valid && result.pressed, !result.released && !result.switch_level)
	`QESW_ASSERT_IMP(a_release_level, clk, arst_n, result_valid && result.released, result.switch_level)

endmodule

bind quadrature_encoder_with_switch_top qesw_checker u_qesw_checker (.*);
